// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      entry_type entry;
   } op_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic      move;
      entry_type entry;
   } link_type;

endpackage
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a pair, shifts right on insert, left on
// remove.
// ----------------------------------------------------------------------------
module spq_cell (
   input  wire logic              clock,
   input  wire spq_pkg::op_type    op,
   input  wire logic              occupied,
   input  wire spq_pkg::link_type  left_link,
   input  wire spq_pkg::entry_type right_entry,
   output spq_pkg::link_type       right_link,
   output spq_pkg::entry_type      entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               move;

   // empty slots and slots holding a larger key make room for the new pair
   assign move = !occupied || (entry_ff.key > op.entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (op.insert_en && move) begin
         entry_in = left_link.move ? left_link.entry : op.entry;
      end else if (op.remove_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign right_link = '{move: move, entry: entry_ff};
   assign entry      = entry_ff;

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of key and data pairs held in a chain of sorted cells.
// ----------------------------------------------------------------------------
// Takes one command per clock (insert, remove smallest key, clear). Every cell
// compares its key with the incoming key at once and shifts in the same cycle;
// the result of a command appears in the output register on the next cycle and
// the input is stalled only while that result is stalled.
// Equal keys leave in arrival order. Insert on a full queue and remove on an
// empty one leave the contents unchanged and report a status code.
module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [spq_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [spq_pkg::KEY_W-1:0]    req_in_key,
   input  wire logic [spq_pkg::VALUE_W-1:0]  req_in_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [spq_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [spq_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [spq_pkg::STAT_W-1:0]        rsp_status,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy,
   output logic [spq_pkg::KEY_W-1:0]         rsp_least_key
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               accept;
   logic               full;
   logic               empty;
   spq_pkg::op_type    op;
   spq_pkg::entry_type cell_entry [CAPACITY];
   spq_pkg::link_type  cell_link  [CAPACITY];

   logic                          rsp_valid_ff;
   logic [spq_pkg::KEY_W-1:0]     out_key_ff,   out_key_in;
   logic [spq_pkg::VALUE_W-1:0]   out_value_ff, out_value_in;
   logic [spq_pkg::STAT_W-1:0]    status_ff,    status_in;
   logic [spq_pkg::KEY_W-1:0]     least_key_ff, least_key_in;
   logic [CNT_W-1:0]              occupancy_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign op = '{
      insert_en: accept && (req_cmd == spq_pkg::CMD_INSERT) && !full,
      remove_en: accept && (req_cmd == spq_pkg::CMD_REMOVE) && !empty,
      entry:     '{key: req_in_key, value: req_in_value}
   };

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::link_type  left_link;
      spq_pkg::entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_link = '0;
      end else begin : g_body
         assign left_link = cell_link[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .occupied    (CNT_W'(i) < count_ff),
         .left_link   (left_link),
         .right_entry (right_entry),
         .right_link  (cell_link[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      out_key_in   = '0;
      out_value_in = '0;
      status_in    = spq_pkg::ST_DONE;
      least_key_in = empty ? '0 : cell_entry[0].key;
      case (req_cmd)
         spq_pkg::CMD_INSERT: begin
            if (full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               if (empty || (cell_entry[0].key > req_in_key)) begin
                  least_key_in = req_in_key;
               end
            end
         end
         spq_pkg::CMD_REMOVE: begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               count_in     = count_ff - CNT_W'(1);
               out_key_in   = cell_entry[0].key;
               out_value_in = cell_entry[0].value;
               // head leaves, the second slot becomes the head
               least_key_in = (count_ff > CNT_W'(1)) ? cell_entry[1].key : '0;
            end
         end
         spq_pkg::CMD_CLEAR: begin
            count_in     = '0;
            least_key_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_key_ff   <= out_key_in;
         out_value_ff <= out_value_in;
         status_ff    <= status_in;
         occupancy_ff <= count_in;
         least_key_ff <= least_key_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = spq_pkg::OCC_W'(occupancy_ff);
   assign rsp_least_key = least_key_ff;

endmodule
`default_nettype wire

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [spq_pkg::KEY_W-1:0]    rsp_out_key,
   input wire logic [spq_pkg::VALUE_W-1:0]  rsp_out_value,
   input wire logic [spq_pkg::STAT_W-1:0]   rsp_status,
   input wire logic [spq_pkg::OCC_W-1:0]    rsp_occupancy,
   input wire logic [spq_pkg::KEY_W-1:0]    rsp_least_key
);

   // every transfer in produces a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after request transfer");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled result changed");

   a_empty_least: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_occupancy == '0) |-> rsp_least_key == '0)
      else $error("least key not zero on empty queue");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::ST_EMPTY) |->
         (rsp_out_key == '0) && (rsp_out_value == '0) && (rsp_occupancy == '0))
      else $error("rejected remove reported data or entries");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_key   (rsp_out_key),
   .rsp_out_value (rsp_out_value),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy),
   .rsp_least_key (rsp_least_key)
);
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// A directed table covers the empty and full cases, the key and data extremes,
// clear, the unused command code and arrival order among equal keys. Bursts of
// random commands follow, leaning toward filling or draining the queue. Typed
// rows are checked against their listed results, all else against a behavioral
// queue in the bench. Both sides idle at random in two phases, a third has none.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY      = 16;
   localparam int RANDOM_ITEMS  = 700;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic [spq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [spq_pkg::KEY_W-1:0]   key;
      logic [spq_pkg::VALUE_W-1:0] value;
      logic [spq_pkg::STAT_W-1:0]  status;
      logic [spq_pkg::OCC_W-1:0]   occupancy;
      logic [spq_pkg::KEY_W-1:0]   least_key;
   } response_type;

   typedef struct packed {
      logic [spq_pkg::CMD_W-1:0]   cmd;
      logic [spq_pkg::KEY_W-1:0]   key;
      logic [spq_pkg::VALUE_W-1:0] value;
      logic                        typed;
      response_type                want;
   } vector_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;
   typedef enum int {KEYS_ANY, KEYS_NARROW, KEYS_EXTREME} key_mix_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [spq_pkg::CMD_W-1:0]     req_cmd = spq_pkg::CMD_INSERT;
   logic [spq_pkg::KEY_W-1:0]     req_in_key = '0;
   logic [spq_pkg::VALUE_W-1:0]   req_in_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [spq_pkg::KEY_W-1:0]     rsp_out_key;
   logic [spq_pkg::VALUE_W-1:0]   rsp_out_value;
   logic [spq_pkg::STAT_W-1:0]    rsp_status;
   logic [spq_pkg::OCC_W-1:0]     rsp_occupancy;
   logic [spq_pkg::KEY_W-1:0]     rsp_least_key;

   // behavioral copy of the queue contents
   logic [spq_pkg::KEY_W-1:0]     held_keys [CAPACITY];
   logic [spq_pkg::VALUE_W-1:0]   held_values [CAPACITY];
   int                            held_count = 0;

   response_type         pending_results [$];
   response_type         arrived;
   vector_type           directed_vectors [$];
   int                   fail_count = 0;
   int                   cycle_count = 0;
   int                   sender_idle_pct = 17;
   int                   receiver_idle_pct = 55;

   sorted_priority_queue #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_in_key    (req_in_key),
      .req_in_value  (req_in_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy),
      .rsp_least_key (rsp_least_key)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   function automatic response_type apply_command(
         input logic [spq_pkg::CMD_W-1:0]   cmd,
         input logic [spq_pkg::KEY_W-1:0]   key,
         input logic [spq_pkg::VALUE_W-1:0] value);
      response_type r;
      int           slot;
      r = '0;
      r.status = spq_pkg::ST_DONE;
      case (cmd)
         spq_pkg::CMD_INSERT: begin
            if (held_count >= CAPACITY) begin
               r.status = spq_pkg::ST_FULL;
            end else begin
               slot = 0;
               // equal keys go behind the ones already held
               while (slot < held_count && held_keys[slot] <= key) slot++;
               for (int i = held_count; i > slot; i--) begin
                  held_keys[i]   = held_keys[i-1];
                  held_values[i] = held_values[i-1];
               end
               held_keys[slot]   = key;
               held_values[slot] = value;
               held_count++;
            end
         end
         spq_pkg::CMD_REMOVE: begin
            if (held_count == 0) begin
               r.status = spq_pkg::ST_EMPTY;
            end else begin
               r.key   = held_keys[0];
               r.value = held_values[0];
               for (int i = 1; i < held_count; i++) begin
                  held_keys[i-1]   = held_keys[i];
                  held_values[i-1] = held_values[i];
               end
               held_count--;
            end
         end
         spq_pkg::CMD_CLEAR: begin
            held_count = 0;
         end
         default: begin
         end
      endcase
      r.occupancy = spq_pkg::OCC_W'(held_count);
      r.least_key = (held_count > 0) ? held_keys[0] : '0;
      return r;
   endfunction

   function automatic vector_type make_vector(
         input logic [spq_pkg::CMD_W-1:0]   cmd,
         input logic [spq_pkg::KEY_W-1:0]   key,
         input logic [spq_pkg::VALUE_W-1:0] value,
         input logic                        typed,
         input logic [spq_pkg::KEY_W-1:0]   out_key,
         input logic [spq_pkg::VALUE_W-1:0] out_value,
         input logic [spq_pkg::STAT_W-1:0]  status,
         input int                          occupancy,
         input logic [spq_pkg::KEY_W-1:0]   least_key);
      vector_type v;
      v.cmd   = cmd;
      v.key   = key;
      v.value = value;
      v.typed = typed;
      v.want  = '{out_key, out_value, status, spq_pkg::OCC_W'(occupancy), least_key};
      return v;
   endfunction

   function automatic void check_field(input string field_name,
                                       input logic [spq_pkg::VALUE_W-1:0] expected_value,
                                       input logic [spq_pkg::VALUE_W-1:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s mismatch: expected %0h, got %0h", field_name, expected_value,
                actual_value);
         fail_count++;
      end
   endfunction

   // decide at the falling edge so the coming rising edge sees settled values
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no command outstanding");
            fail_count++;
         end else begin
            arrived = pending_results.pop_front();
            check_field("out_key", spq_pkg::VALUE_W'(arrived.key),
                        spq_pkg::VALUE_W'(rsp_out_key));
            check_field("out_value", arrived.value, rsp_out_value);
            check_field("status", spq_pkg::VALUE_W'(arrived.status),
                        spq_pkg::VALUE_W'(rsp_status));
            check_field("occupancy", spq_pkg::VALUE_W'(arrived.occupancy),
                        spq_pkg::VALUE_W'(rsp_occupancy));
            check_field("least_key", spq_pkg::VALUE_W'(arrived.least_key),
                        spq_pkg::VALUE_W'(rsp_least_key));
         end
      end
   end

   task automatic send_command(input vector_type v);
      response_type predicted;
      logic         taken;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= v.cmd;
      req_in_key   <= v.key;
      req_in_value <= v.value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predicted = apply_command(v.cmd, v.key, v.value);
      pending_results.push_back(v.typed ? v.want : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      vector_type  v;
      mix_type     mix;
      key_mix_type key_mix;
      int          roll;

      // empty queue, extremes, unused code, clear with content
      directed_vectors.push_back(make_vector(spq_pkg::CMD_REMOVE, 16'h0000, 32'h0, 1'b1,
                                 16'h0000, 32'h0, spq_pkg::ST_EMPTY, 0, 16'h0000));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF,
                                 1'b1, 16'h0000, 32'h0, spq_pkg::ST_DONE, 1, 16'hFFFF));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_INSERT, 16'h0000, 32'h0, 1'b1,
                                 16'h0000, 32'h0, spq_pkg::ST_DONE, 2, 16'h0000));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_REMOVE, 16'h1111, 32'h2222_2222,
                                 1'b1, 16'h0000, 32'h0, spq_pkg::ST_DONE, 1, 16'hFFFF));
      directed_vectors.push_back(make_vector(CMD_UNUSED, 16'h1234, 32'h5678_9ABC, 1'b1,
                                 16'h0000, 32'h0, spq_pkg::ST_DONE, 1, 16'hFFFF));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_REMOVE, 16'h0000, 32'h0, 1'b1,
                                 16'hFFFF, 32'hFFFF_FFFF, spq_pkg::ST_DONE, 0, 16'h0000));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_INSERT, 16'h8000, 32'h5A5A_5A5A,
                                 1'b1, 16'h0000, 32'h0, spq_pkg::ST_DONE, 1, 16'h8000));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF,
                                 1'b1, 16'h0000, 32'h0, spq_pkg::ST_DONE, 0, 16'h0000));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_REMOVE, 16'h0000, 32'h0, 1'b1,
                                 16'h0000, 32'h0, spq_pkg::ST_EMPTY, 0, 16'h0000));
      // fill to capacity; every fourth pair shares the smallest key
      for (int i = 0; i < CAPACITY; i++) begin
         directed_vectors.push_back(make_vector(spq_pkg::CMD_INSERT,
                                    (i % 4 == 0) ? 16'h0040 : 16'(16'h0040 + i * 37),
                                    32'hA500_0000 + i, 1'b0,
                                    '0, '0, spq_pkg::ST_DONE, 0, '0));
      end
      directed_vectors.push_back(make_vector(spq_pkg::CMD_INSERT, 16'h0000, 32'h1234_5678,
                                 1'b1, 16'h0000, 32'h0, spq_pkg::ST_FULL, CAPACITY,
                                 16'h0040));
      // first of the equal smallest keys must leave first
      directed_vectors.push_back(make_vector(spq_pkg::CMD_REMOVE, 16'h0000, 32'h0, 1'b1,
                                 16'h0040, 32'hA500_0000, spq_pkg::ST_DONE, CAPACITY - 1,
                                 16'h0040));
      directed_vectors.push_back(make_vector(spq_pkg::CMD_CLEAR, 16'h0000, 32'h0, 1'b1,
                                 16'h0000, 32'h0, spq_pkg::ST_DONE, 0, 16'h0000));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i]) send_command(directed_vectors[i]);

      mix     = MIX_FILL;
      key_mix = KEYS_ANY;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            wait_drained();
            sender_idle_pct   = 55;
            receiver_idle_pct = 17;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            wait_drained();
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (n % 20 == 0) begin
            mix     = mix_type'($urandom_range(0, 2));
            key_mix = key_mix_type'($urandom_range(0, 2));
         end
         v = '0;
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL:  v.cmd = (roll < 75) ? spq_pkg::CMD_INSERT :
                               (roll < 95) ? spq_pkg::CMD_REMOVE :
                               (roll < 98) ? spq_pkg::CMD_CLEAR : CMD_UNUSED;
            MIX_DRAIN: v.cmd = (roll < 20) ? spq_pkg::CMD_INSERT :
                               (roll < 95) ? spq_pkg::CMD_REMOVE :
                               (roll < 98) ? spq_pkg::CMD_CLEAR : CMD_UNUSED;
            default:   v.cmd = (roll < 48) ? spq_pkg::CMD_INSERT :
                               (roll < 96) ? spq_pkg::CMD_REMOVE :
                               (roll < 98) ? spq_pkg::CMD_CLEAR : CMD_UNUSED;
         endcase
         case (key_mix)
            KEYS_NARROW:  v.key = spq_pkg::KEY_W'($urandom_range(0, 7));
            KEYS_EXTREME: v.key = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default:      v.key = spq_pkg::KEY_W'($urandom);
         endcase
         v.value = $urandom;
         send_command(v);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
test/tb.sv
